### rtl/core/bctd_pkg.sv
`default_nettype none

package bctd_pkg;

    // Item field widths
    localparam int OP_BITS     = 2;
    localparam int BUTTON_BITS = 4;
    localparam int LINE_BITS   = 6;
    localparam int KIND_BITS   = 3;
    localparam int TAP_BITS    = 3;

    // Defaults for the module parameters
    localparam int BUTTON_COUNT_DEFAULT = 6;
    localparam int TIMER_BITS_DEFAULT   = 16;

    // Configuration port
    localparam int CFG_BITS   = 16;
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 5;
    localparam int INDEX_BITS = 3;

    localparam logic [INDEX_BITS-1:0] REG_FACTORY  = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_REBOOT   = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_INFO     = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_JOIN     = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_STAFF    = 3'd4;
    localparam logic [INDEX_BITS-1:0] REG_RECOVERY = 3'd5;

    localparam logic [CFG_BITS-1:0] FACTORY_HOLD_RESET  = 16'd10000;
    localparam logic [CFG_BITS-1:0] REBOOT_HOLD_RESET   = 16'd5000;
    localparam logic [CFG_BITS-1:0] INFO_HOLD_RESET     = 16'd3000;
    localparam logic [CFG_BITS-1:0] JOIN_HOLD_RESET     = 16'd3000;
    localparam logic [CFG_BITS-1:0] STAFF_HOLD_RESET    = 16'd3000;
    localparam logic [CFG_BITS-1:0] RECOVERY_IDLE_RESET = 16'd2000;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_PRESS   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TICK    = 2'd2;

    // Event kinds; the combo kinds double as combo indexes
    localparam logic [KIND_BITS-1:0] KIND_FACTORY = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_REBOOT  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_INFO    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_JOIN    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_STAFF   = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_TAP     = 3'd5;

    localparam int NUM_COMBOS = 5;

    // Fixed combo masks (the factory combo is all buttons)
    localparam logic [5:0] REBOOT_MASK = 6'h0F;
    localparam logic [5:0] INFO_MASK   = 6'h23;
    localparam logic [5:0] JOIN_MASK   = 6'h07;
    localparam logic [5:0] STAFF_MASK  = 6'h03;

endpackage

`default_nettype wire

### rtl/core/bctd_in_if.sv
`default_nettype none

interface bctd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [bctd_pkg::OP_BITS-1:0]         op;
    logic [bctd_pkg::BUTTON_BITS-1:0]     button;
    logic [bctd_pkg::LINE_BITS-1:0]       line_held_mask;

    modport source (output valid, output op, output button, output line_held_mask,
                    input ready);
    modport sink (input valid, input op, input button, input line_held_mask,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/bctd_out_if.sv
`default_nettype none

interface bctd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 event_valid;
    logic [bctd_pkg::KIND_BITS-1:0]       event_kind;
    logic [bctd_pkg::TAP_BITS-1:0]        tap_button;
    logic [bctd_pkg::LINE_BITS-1:0]       held_mask_out;

    modport source (output valid, output event_valid, output event_kind,
                    output tap_button, output held_mask_out, input ready);
    modport sink (input valid, input event_valid, input event_kind,
                  input tap_button, input held_mask_out, output ready);
endinterface

`default_nettype wire

### rtl/core/button_combo_tap_detector.sv
// Channel   Role    Beat contents
// items     sink    op, button, line_held_mask
// results   source  event_valid, event_kind, tap_button, held_mask_out
// apb       slave   six 16-bit hold and idle time registers at byte address 4*i
//
// Every item beat yields exactly one result beat, valid from the cycle after acceptance.
// The whole update is one combinational pass from the state registers into the
// state and result registers, so one item is taken per cycle unless input is stalled.
// A full result register stalls input only while results.ready is low.
// Reset clears all tracking state and loads the default hold and idle times.
`default_nettype none

module button_combo_tap_detector #(
    parameter int BUTTON_COUNT = bctd_pkg::BUTTON_COUNT_DEFAULT,
    parameter int TIMER_BITS   = bctd_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bctd_in_if.sink                                items,
    bctd_out_if.source                             results,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bctd_pkg::ADDR_BITS-1:0]    paddr,
    input  wire logic [bctd_pkg::DATA_BITS-1:0]    pwdata,
    output logic [bctd_pkg::DATA_BITS-1:0]         prdata,
    output logic                                   pready
);

    localparam int BC       = BUTTON_COUNT;
    localparam int TB       = TIMER_BITS;
    localparam int CMP_BITS = (TB > bctd_pkg::CFG_BITS) ? TB : bctd_pkg::CFG_BITS;
    localparam int IDX_BITS = bctd_pkg::KIND_BITS;

    localparam logic [BC-1:0] COMBO_MASK [bctd_pkg::NUM_COMBOS] = '{
        {BC{1'b1}},
        BC'(bctd_pkg::REBOOT_MASK),
        BC'(bctd_pkg::INFO_MASK),
        BC'(bctd_pkg::JOIN_MASK),
        BC'(bctd_pkg::STAFF_MASK)
    };

    typedef struct packed {
        logic                armed;
        logic [IDX_BITS-1:0] idx;
        logic [TB-1:0]       elapsed;
    } arm_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [bctd_pkg::CFG_BITS-1:0] factory_hold_reg, reboot_hold_reg, info_hold_reg;
    logic [bctd_pkg::CFG_BITS-1:0] join_hold_reg, staff_hold_reg, recovery_idle_reg;
    logic [bctd_pkg::INDEX_BITS-1:0] reg_index;
    logic                            cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[bctd_pkg::ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factory_hold_reg  <= bctd_pkg::FACTORY_HOLD_RESET;
            reboot_hold_reg   <= bctd_pkg::REBOOT_HOLD_RESET;
            info_hold_reg     <= bctd_pkg::INFO_HOLD_RESET;
            join_hold_reg     <= bctd_pkg::JOIN_HOLD_RESET;
            staff_hold_reg    <= bctd_pkg::STAFF_HOLD_RESET;
            recovery_idle_reg <= bctd_pkg::RECOVERY_IDLE_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                bctd_pkg::REG_FACTORY:  factory_hold_reg  <= pwdata[bctd_pkg::CFG_BITS-1:0];
                bctd_pkg::REG_REBOOT:   reboot_hold_reg   <= pwdata[bctd_pkg::CFG_BITS-1:0];
                bctd_pkg::REG_INFO:     info_hold_reg     <= pwdata[bctd_pkg::CFG_BITS-1:0];
                bctd_pkg::REG_JOIN:     join_hold_reg     <= pwdata[bctd_pkg::CFG_BITS-1:0];
                bctd_pkg::REG_STAFF:    staff_hold_reg    <= pwdata[bctd_pkg::CFG_BITS-1:0];
                bctd_pkg::REG_RECOVERY: recovery_idle_reg <= pwdata[bctd_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            bctd_pkg::REG_FACTORY:  prdata = bctd_pkg::DATA_BITS'(factory_hold_reg);
            bctd_pkg::REG_REBOOT:   prdata = bctd_pkg::DATA_BITS'(reboot_hold_reg);
            bctd_pkg::REG_INFO:     prdata = bctd_pkg::DATA_BITS'(info_hold_reg);
            bctd_pkg::REG_JOIN:     prdata = bctd_pkg::DATA_BITS'(join_hold_reg);
            bctd_pkg::REG_STAFF:    prdata = bctd_pkg::DATA_BITS'(staff_hold_reg);
            bctd_pkg::REG_RECOVERY: prdata = bctd_pkg::DATA_BITS'(recovery_idle_reg);
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Tracking state
    // ---------------------------------------------------------------
    logic [BC-1:0] held_reg, held_next;
    logic [BC-1:0] session_reg, session_next;
    logic [BC-1:0] last_fired_reg, last_fired_next;
    logic          fired_reg, fired_next;
    arm_t          arm_reg, arm_next;
    logic          idle_valid_reg, idle_valid_next;
    logic [TB-1:0] idle_elapsed_reg, idle_elapsed_next;

    logic                             res_valid_reg;
    logic                             event_valid_reg, event_valid_next;
    logic [bctd_pkg::KIND_BITS-1:0]   event_kind_reg, event_kind_next;
    logic [bctd_pkg::TAP_BITS-1:0]    tap_button_reg, tap_button_next;
    logic [bctd_pkg::LINE_BITS-1:0]   held_out_reg;

    logic accept;

    assign items.ready = !res_valid_reg || results.ready;
    assign accept      = items.valid && items.ready;

    // Re-arms the hold timer when the held set matches a combo not yet fired; otherwise disarms it.
    function automatic arm_t sync_timer(input logic [BC-1:0] h, input logic [BC-1:0] lf,
                                        input arm_t cur);
        arm_t                res;
        logic                hit;
        logic [IDX_BITS-1:0] m;
        res = cur;
        hit = 1'b0;
        m   = '0;
        for (int i = bctd_pkg::NUM_COMBOS - 1; i >= 0; i--)
        begin
            if (COMBO_MASK[i] == h)
            begin
                hit = 1'b1;
                m   = IDX_BITS'(i);
            end
        end
        if (hit && h != lf)
        begin
            if (!cur.armed || cur.idx != m)
            begin
                res.armed   = 1'b1;
                res.idx     = m;
                res.elapsed = '0;
            end
        end
        else
        begin
            res.armed = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [TB-1:0] sat_inc(input logic [TB-1:0] v);
        return (v == {TB{1'b1}}) ? v : v + TB'(1);
    endfunction

    logic [bctd_pkg::CFG_BITS-1:0] hold_time;
    logic [BC-1:0]                 armed_mask;
    logic                          btn_ok;
    logic [BC-1:0]                 btn_bit;

    always_comb
    begin
        case (arm_reg.idx)
            bctd_pkg::KIND_FACTORY: hold_time = factory_hold_reg;
            bctd_pkg::KIND_REBOOT:  hold_time = reboot_hold_reg;
            bctd_pkg::KIND_INFO:    hold_time = info_hold_reg;
            bctd_pkg::KIND_JOIN:    hold_time = join_hold_reg;
            bctd_pkg::KIND_STAFF:   hold_time = staff_hold_reg;
            default:                hold_time = '0;
        endcase
        case (arm_reg.idx)
            bctd_pkg::KIND_FACTORY: armed_mask = COMBO_MASK[0];
            bctd_pkg::KIND_REBOOT:  armed_mask = COMBO_MASK[1];
            bctd_pkg::KIND_INFO:    armed_mask = COMBO_MASK[2];
            bctd_pkg::KIND_JOIN:    armed_mask = COMBO_MASK[3];
            bctd_pkg::KIND_STAFF:   armed_mask = COMBO_MASK[4];
            default:                armed_mask = '0;
        endcase
    end

    assign btn_ok  = 32'(items.button) < 32'(BC);
    assign btn_bit = BC'(1) << items.button;

    always_comb
    begin
        held_next         = held_reg;
        session_next      = session_reg;
        last_fired_next   = last_fired_reg;
        fired_next        = fired_reg;
        arm_next          = arm_reg;
        idle_valid_next   = idle_valid_reg;
        idle_elapsed_next = idle_elapsed_reg;
        event_valid_next  = 1'b0;
        event_kind_next   = '0;
        tap_button_next   = '0;

        if ((items.op == bctd_pkg::OP_PRESS || items.op == bctd_pkg::OP_RELEASE) && btn_ok)
        begin
            if (items.op == bctd_pkg::OP_PRESS)
            begin
                held_next    = held_reg | btn_bit;
                session_next = session_reg | btn_bit;
            end
            else
            begin
                held_next = held_reg & ~btn_bit;
            end

            if (held_next == '0)
            begin
                if (!idle_valid_reg)
                begin
                    idle_valid_next   = 1'b1;
                    idle_elapsed_next = '0;
                end
            end
            else
            begin
                idle_valid_next = 1'b0;
            end

            arm_next = sync_timer(held_next, last_fired_reg, arm_reg);

            // Last button up closes the session; a lone untouched button is a tap.
            if (items.op == bctd_pkg::OP_RELEASE && held_next == '0 && session_next != '0)
            begin
                if (!fired_reg && $onehot(session_next))
                begin
                    event_valid_next = 1'b1;
                    event_kind_next  = bctd_pkg::KIND_TAP;
                    for (int i = 0; i < BC; i++)
                    begin
                        if (session_next[i])
                        begin
                            tap_button_next = tap_button_next | bctd_pkg::TAP_BITS'(i);
                        end
                    end
                end
                session_next      = '0;
                fired_next        = 1'b0;
                last_fired_next   = '0;
                idle_valid_next   = 1'b0;
                idle_elapsed_next = '0;
                arm_next.armed    = 1'b0;
            end
        end
        else if (items.op == bctd_pkg::OP_TICK)
        begin
            if (arm_reg.armed)
            begin
                arm_next.elapsed = sat_inc(arm_reg.elapsed);
            end
            if (idle_valid_reg)
            begin
                idle_elapsed_next = sat_inc(idle_elapsed_reg);
            end

            if (arm_reg.armed && held_reg == armed_mask && armed_mask != '0 &&
                CMP_BITS'(arm_next.elapsed) >= CMP_BITS'(hold_time))
            begin
                event_valid_next = 1'b1;
                event_kind_next  = arm_reg.idx;
                fired_next       = 1'b1;
                last_fired_next  = armed_mask;
                arm_next.armed   = 1'b0;
            end

            // Recovery: after a long idle, trust the raw line levels.
            if (held_reg == '0 && session_reg != '0 && idle_valid_reg &&
                CMP_BITS'(idle_elapsed_next) >= CMP_BITS'(recovery_idle_reg))
            begin
                held_next = BC'(items.line_held_mask);
                if (held_next != '0)
                begin
                    idle_valid_next = 1'b0;
                    arm_next        = sync_timer(held_next, last_fired_next, arm_next);
                end
                else
                begin
                    session_next      = '0;
                    fired_next        = 1'b0;
                    last_fired_next   = '0;
                    idle_valid_next   = 1'b0;
                    idle_elapsed_next = '0;
                    arm_next.armed    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= '0;
            session_reg      <= '0;
            last_fired_reg   <= '0;
            fired_reg        <= 1'b0;
            arm_reg          <= '0;
            idle_valid_reg   <= 1'b0;
            idle_elapsed_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg         <= held_next;
                session_reg      <= session_next;
                last_fired_reg   <= last_fired_next;
                fired_reg        <= fired_next;
                arm_reg          <= arm_next;
                idle_valid_reg   <= idle_valid_next;
                idle_elapsed_reg <= idle_elapsed_next;
                res_valid_reg    <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_valid_reg <= event_valid_next;
            event_kind_reg  <= event_kind_next;
            tap_button_reg  <= tap_button_next;
            held_out_reg    <= held_next[bctd_pkg::LINE_BITS-1:0];
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.event_valid   = event_valid_reg;
    assign results.event_kind    = event_kind_reg;
    assign results.tap_button    = tap_button_reg;
    assign results.held_mask_out = held_out_reg;

endmodule

`default_nettype wire
